>>> design/wbps_pkg.sv
package wbps_pkg;

    localparam int PAT_BYTES = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [47:0] match_address;
    } out_item_t;

    typedef enum logic [2:0] {
        CFG_BASE_ADDRESS   = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_CARE_MASK      = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4,
        CFG_RESULT_OFFSET  = 3'd5
    } cfg_index_t;

    // per-cycle control shared by every cell of the window chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // what one cell compares against, already aligned to its window slot
    typedef struct packed {
        logic [7:0] pat;
        logic       care;
        logic       active;
        logic       need_here;
    } cell_ref_t;

    function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] idx);
        logic [127:0] all;
        all = {hi, lo};
        return all[{idx, 3'b000} +: 8];
    endfunction

endpackage

>>> design/wbps_cell.sv
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctl_t  ctl,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    input  cell_ref_t  cref,
    output logic [7:0] data_out,
    output logic       valid_out,
    output logic       ok
);

    logic [7:0] data_reg;
    logic       valid_reg;
    logic [7:0] data_next;
    logic       valid_next;
    logic       sh_valid;

    assign data_next = ctl.shift ? in_byte : data_reg;
    assign sh_valid  = ctl.shift ? in_valid : valid_reg;
    assign valid_next = ctl.clear ? 1'b0 : sh_valid;

    // judged on the window as it stands after this item shifts in
    assign ok = (!cref.active || !cref.care || (data_next == cref.pat)) &&
                (!cref.need_here || sh_valid);

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

>>> design/wildcard_byte_pattern_scanner.sv
// Wildcard byte signature scanner.
// Input channel s_valid/s_ready/s_item carries one memory byte per item; the
// byte with last_byte set closes the scan range. Result channel
// m_valid/m_ready/m_item gives at most one item per range: found with the
// match start address (base + position + signed offset, wrapping at
// ADDR_BITS), or found clear with a zero address when the range ends without
// a match. Bytes after a match are consumed silently.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must
// write it only while the scanner is idle, the block leaves this to the user; cfg_ready is always high.
// Throughput is one byte per cycle while s_ready is high. A result is registered
// first in the adder stage, which holds the window compare outcome and start
// position, and then in the output register, which takes the address sum.
// A stalled receiver holds the output register; one more result may wait in
// the adder stage, after which s_ready drops until the output drains.
// Synchronous reset clears the window, position, pending results and loads
// the register defaults (care mask all ones, pattern length one).
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CLW = $clog2(MAX_PATTERN + 1);
    localparam int LW  = (CLW > 5) ? CLW : 5;

    // configuration
    logic [47:0] base_reg;
    logic [63:0] pat_lo_reg;
    logic [63:0] pat_hi_reg;
    logic [15:0] care_reg;
    logic [4:0]  len_reg;
    logic [31:0] off_reg;
    logic [ADDR_BITS-1:0] base_off_reg;
    logic [ADDR_BITS-1:0] base_off_next;
    logic [63:0] base_off64;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= 16'hFFFF;
            len_reg    <= 5'd1;
            off_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BASE_ADDRESS:   base_reg   <= cfg_data[47:0];
                CFG_PATTERN_LOW:    pat_lo_reg <= cfg_data;
                CFG_PATTERN_HIGH:   pat_hi_reg <= cfg_data;
                CFG_CARE_MASK:      care_reg   <= cfg_data[15:0];
                CFG_PATTERN_LENGTH: len_reg    <= cfg_data[4:0];
                CFG_RESULT_OFFSET:  off_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // base plus sign-extended offset, refreshed every cycle from config
    assign base_off64    = {16'b0, base_reg} + {{32{off_reg[31]}}, off_reg};
    assign base_off_next = base_off64[ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        base_off_reg <= base_off_next;
    end

    // effective length and the slot that must hold a valid byte
    logic [LW-1:0] len_ext;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] need_m1;

    assign len_ext = LW'(len_reg);
    assign len_eff = (len_ext > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : len_ext;
    assign need_m1 = (len_eff == '0) ? '0 : len_eff - LW'(1);

    // handshake and pipeline control
    logic b_valid_reg;
    logic b_found_reg;
    logic [ADDR_BITS-1:0] b_start_reg;
    logic m_valid_reg;
    out_item_t m_item_reg;
    logic out_ok;
    logic s_fire;
    logic done_reg;
    logic [ADDR_BITS-1:0] pos_reg;
    logic hit;
    logic emit;
    cell_ctl_t ctl;

    assign out_ok  = !m_valid_reg || m_ready;
    assign s_ready = !b_valid_reg || out_ok;
    assign s_fire  = s_valid && s_ready;

    assign ctl.shift = s_fire && !done_reg;
    assign ctl.clear = s_fire && s_item.last_byte;

    // window cell chain, slot 0 holds the newest byte
    logic [7:0]             cell_data [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_valid;
    logic [MAX_PATTERN-1:0] cell_ok;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        cell_ref_t     cref;
        logic [LW-1:0] idx;
        logic [7:0]    in_byte;
        logic          in_valid;

        assign idx = len_eff - LW'(1) - LW'(k);
        assign cref.active    = LW'(k) < len_eff;
        assign cref.need_here = LW'(k) == need_m1;
        assign cref.pat       = pat_byte(pat_lo_reg, pat_hi_reg, idx[3:0]);
        // pattern slots past the sixteenth are wildcards
        assign cref.care      = (idx < LW'(PAT_BYTES)) && care_reg[idx[3:0]];

        if (k == 0) begin : g_head
            assign in_byte  = s_item.data_byte;
            assign in_valid = 1'b1;
        end else begin : g_link
            assign in_byte  = cell_data[k-1];
            assign in_valid = cell_valid[k-1];
        end

        wbps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .in_byte   (in_byte),
            .in_valid  (in_valid),
            .cref      (cref),
            .data_out  (cell_data[k]),
            .valid_out (cell_valid[k]),
            .ok        (cell_ok[k])
        );
    end

    assign hit  = ctl.shift && (&cell_ok);
    assign emit = hit || (ctl.shift && s_item.last_byte);

    // range position and match latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (s_fire) begin
            if (s_item.last_byte) begin
                done_reg <= 1'b0;
                pos_reg  <= '0;
            end else begin
                if (hit) begin
                    done_reg <= 1'b1;
                end
                if (!done_reg) begin
                    pos_reg <= pos_reg + ADDR_BITS'(1);
                end
            end
        end
    end

    // adder stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= s_fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            b_found_reg <= hit;
            b_start_reg <= pos_reg - ADDR_BITS'(need_m1);
        end
    end

    // output register
    logic [ADDR_BITS-1:0] addr_sum;
    logic [63:0]          addr64;
    out_item_t            m_item_next;

    assign addr_sum = base_off_reg + b_start_reg;
    assign addr64   = 64'(addr_sum);
    assign m_item_next.found         = b_found_reg;
    assign m_item_next.match_address = b_found_reg ? addr64[47:0] : 48'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ok) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ok) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.found |-> m_item.match_address == 48'd0)
        else $error("not-found item carries a nonzero address");

    a_range_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.last_byte |=> !done_reg && pos_reg == '0)
        else $error("range state not cleared after last byte");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken while both result stages are full");

    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && s_valid && s_ready |=> !b_valid_reg)
        else $error("result raised for a byte after a match");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
    import wbps_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    wildcard_byte_pattern_scanner u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    in_item_t  bytes_to_send[$];
    out_item_t predicted_matches[$];
    int        mismatches = 0;
    int        bytes_taken = 0;
    bit        no_idle = 1'b0;

    // scanner copy: registers
    logic [47:0]  cfg_base;
    logic [127:0] cfg_pattern;
    logic [15:0]  cfg_care;
    logic [4:0]   cfg_len;
    logic [31:0]  cfg_offset;
    // scanner copy: range state, window[0] is the newest byte
    logic [7:0]   window [16];
    logic [47:0]  byte_pos;
    bit           range_done;
    int           fill;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    task automatic log_mismatch(input string what);
        $display("testbench: mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_range();
        for (int i = 0; i < 16; i++) window[i] = 8'h00;
        byte_pos = '0;
        range_done = 1'b0;
        fill = 0;
    endtask

    task automatic scan_byte(input in_item_t it);
        int          len;
        int          need;
        bit          hit;
        logic [47:0] here;
        out_item_t   r;
        if (!range_done) begin
            len = (cfg_len > 16) ? 16 : int'(cfg_len);
            need = (len == 0) ? 1 : len;
            here = byte_pos;
            for (int i = 15; i > 0; i--) window[i] = window[i-1];
            window[0] = it.data_byte;
            if (fill < 16) fill++;
            byte_pos = byte_pos + 48'd1;
            hit = (fill >= need);
            for (int i = 0; i < len; i++) begin
                if (cfg_care[i] && window[len-1-i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                r.found = 1'b1;
                r.match_address = cfg_base + (here - 48'(need - 1))
                                  + {{16{cfg_offset[31]}}, cfg_offset};
                range_done = 1'b1;
                predicted_matches = {predicted_matches, r};
            end else if (it.last_byte) begin
                r = '0;
                predicted_matches = {predicted_matches, r};
            end
        end
        if (it.last_byte) clear_range();
    endtask

    // predict on accepted bytes and register writes, then check results
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            cfg_base = '0;
            cfg_pattern = '0;
            cfg_care = 16'hFFFF;
            cfg_len = 5'd1;
            cfg_offset = '0;
            clear_range();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_BASE_ADDRESS:   cfg_base = cfg_data[47:0];
                    CFG_PATTERN_LOW:    cfg_pattern[63:0] = cfg_data;
                    CFG_PATTERN_HIGH:   cfg_pattern[127:64] = cfg_data;
                    CFG_CARE_MASK:      cfg_care = cfg_data[15:0];
                    CFG_PATTERN_LENGTH: cfg_len = cfg_data[4:0];
                    CFG_RESULT_OFFSET:  cfg_offset = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                scan_byte(s_item);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (predicted_matches.size() == 0) begin
                    log_mismatch($sformatf("unexpected result found=%0b addr=%h",
                                           m_item.found, m_item.match_address));
                end else begin
                    want = predicted_matches.pop_front();
                    if (m_item.found !== want.found)
                        log_mismatch($sformatf("found %0b, want %0b",
                                               m_item.found, want.found));
                    if (m_item.match_address !== want.match_address)
                        log_mismatch($sformatf("match_address %h, want %h",
                                               m_item.match_address, want.match_address));
                end
            end
        end
    end

    // byte sender
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (bytes_to_send.size() > 0) begin
                if (!no_idle && $urandom_range(0, 15) == 0) begin
                    s_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 6);
                end else begin
                    s_valid <= 1'b1;
                    s_item <= bytes_to_send.pop_front();
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver; one long hold-off lets the output side back up
    int stall_left = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_left > 0) begin
            m_ready <= 1'b0;
            long_hold_left <= long_hold_left - 1;
        end else if (!long_hold_done && bytes_taken >= 700) begin
            m_ready <= 1'b0;
            long_hold_left <= 80;
            long_hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic cfg_write(input cfg_index_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(input logic [47:0] base, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [15:0] care,
                              input logic [4:0] len, input logic [31:0] off);
        cfg_write(CFG_BASE_ADDRESS, {16'h0, base});
        cfg_write(CFG_PATTERN_LOW, lo);
        cfg_write(CFG_PATTERN_HIGH, hi);
        cfg_write(CFG_CARE_MASK, {48'h0, care});
        cfg_write(CFG_PATTERN_LENGTH, {59'h0, len});
        cfg_write(CFG_RESULT_OFFSET, {32'h0, off});
        // let the copy above pick up the last write
        @(posedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        bytes_to_send = {bytes_to_send, it};
    endtask

    // random range, optionally with the pattern planted (and maybe spoiled)
    task automatic queue_range(input int n, input bit plant, input bit spoil);
        logic [7:0] buf_q [$];
        int eff;
        int at;
        int k;
        eff = (cfg_len > 16) ? 16 : int'(cfg_len);
        for (k = 0; k < n; k++) buf_q = {buf_q, 8'($urandom_range(0, 255))};
        if (plant && eff > 0 && n >= eff) begin
            at = $urandom_range(0, n - eff);
            for (k = 0; k < eff; k++)
                if (cfg_care[k]) buf_q[at+k] = cfg_pattern[8*k +: 8];
            if (spoil) begin
                k = $urandom_range(0, eff - 1);
                if (cfg_care[k]) buf_q[at+k] = ~cfg_pattern[8*k +: 8];
            end
        end
        for (k = 0; k < n; k++) send_byte(buf_q[k], k == n - 1);
    endtask

    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || s_valid || predicted_matches.size() != 0)
            @(posedge aclk);
        // bytes after a match give nothing; let the pipeline settle
        repeat (4) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          phase;
        int          queued;
        int          n;
        logic [4:0]  plen;
        logic [15:0] care;
        logic [47:0] base;
        logic [31:0] off;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: one-byte pattern 00
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_idle();

        // AA ?? CC matching on the last byte, address wraps past the top
        load_setup(48'hFFFF_FFFF_FFF0, 64'h0000_0000_00CC_00AA, 64'hFFFF_FFFF_FFFF_FFFF,
                   16'h0005, 5'd3, 32'h7FFF_FFFF);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hCC, 1'b1);
        wait_idle();

        // empty pattern: first byte matches, most negative offset
        load_setup(48'h0, 64'h0, 64'h0, 16'hFFFF, 5'd0, 32'h8000_0000);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h5B, 1'b1);
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: plen = 5'd16;
                1: plen = 5'd1;
                2: plen = 5'd0;
                3: plen = 5'd31;
                4: plen = 5'd17;
                default: plen = 5'($urandom_range(1, 16));
            endcase
            case (phase)
                0, 3: care = 16'hFFFF;
                1: care = 16'h0000;
                default: care = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 65535));
            endcase
            case (phase)
                0: base = 48'hFFFF_FFFF_FFFF;
                1: base = 48'h0;
                default: base = {16'($urandom), $urandom};
            endcase
            case (phase)
                0: off = 32'h7FFF_FFFF;
                1: off = 32'h8000_0000;
                2: off = 32'h0;
                default: off = $urandom;
            endcase
            load_setup(base, {$urandom, $urandom}, {$urandom, $urandom}, care, plen, off);
            if (phase == 7) no_idle = 1'b1;

            queued = 0;
            while (queued < 250) begin
                if (plen == 5'd0) n = $urandom_range(1, 3);
                else if ($urandom_range(0, 4) == 0) n = $urandom_range(25, 64);
                else n = $urandom_range(1, 24);
                queue_range(n, $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 15);
                queued += n;
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
